// ----- rtl/kchs_pkg.sv -----
package kchs_pkg;

    localparam int MAX_CHANNELS_DEF = 64;
    localparam int SF_W    = 32;
    localparam int HOP_W   = 6;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 7;
    localparam int VAR_W   = 2;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CIDX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_COUNT    = 2'd2;
    localparam logic [CIDX_W-1:0] REG_VARIANT  = 2'd3;

    localparam logic [VAR_W-1:0] VAR_BIG    = 2'd0;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] bs;
        logic [7:0] s;
        r  = 8'h01;
        bs = x;
        for (int k = 0; k < 8; k++) begin
            if (k != 0) r = gmul(r, bs);
            bs = gmul(bs, bs);
        end
        s = r ^ 8'h63 ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
            ^ {r[3:0], r[7:4]};
        sbox = s;
    endfunction

    typedef logic [7:0] t_sbox_tab [256];

    function automatic t_sbox_tab build_sbox();
        t_sbox_tab t;
        for (int i = 0; i < 256; i++) t[i] = sbox(8'(i));
        build_sbox = t;
    endfunction

    localparam t_sbox_tab SBOX = build_sbox();

endpackage

// ----- rtl/kchs_aes.sv -----
module kchs_aes
    import kchs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    input  logic [127:0] i_block,
    output logic         o_done,
    output logic [127:0] o_block
);

    logic [127:0] r_st;
    logic [127:0] r_rk;
    logic [7:0]   r_rcon;
    logic [3:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [127:0] n_rk;
    logic [127:0] sub;
    logic [127:0] shf;
    logic [127:0] mix;
    logic [127:0] n_st;
    logic [31:0]  w3;
    logic [31:0]  tw;

    function automatic logic [7:0] byt(input logic [127:0] v, input int i);
        byt = v[127-8*i -: 8];
    endfunction

    always_comb begin
        w3 = r_rk[31:0];
        tw = {SBOX[w3[23:16]] ^ r_rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n_rk[127:96] = r_rk[127:96] ^ tw;
        n_rk[95:64]  = r_rk[95:64] ^ n_rk[127:96];
        n_rk[63:32]  = r_rk[63:32] ^ n_rk[95:64];
        n_rk[31:0]   = r_rk[31:0] ^ n_rk[63:32];
        for (int i = 0; i < 16; i++) sub[127-8*i -: 8] = SBOX[byt(r_st, i)];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                shf[127-8*(i+4*c) -: 8] = byt(sub, i + 4 * ((c + i) & 3));
        for (int c = 0; c < 4; c++) begin
            mix[127-8*(4*c) -: 8]   = xtime(byt(shf, 4*c)) ^ xtime(byt(shf, 4*c+1))
                ^ byt(shf, 4*c+1) ^ byt(shf, 4*c+2) ^ byt(shf, 4*c+3);
            mix[127-8*(4*c+1) -: 8] = byt(shf, 4*c) ^ xtime(byt(shf, 4*c+1))
                ^ xtime(byt(shf, 4*c+2)) ^ byt(shf, 4*c+2) ^ byt(shf, 4*c+3);
            mix[127-8*(4*c+2) -: 8] = byt(shf, 4*c) ^ byt(shf, 4*c+1)
                ^ xtime(byt(shf, 4*c+2)) ^ xtime(byt(shf, 4*c+3)) ^ byt(shf, 4*c+3);
            mix[127-8*(4*c+3) -: 8] = xtime(byt(shf, 4*c)) ^ byt(shf, 4*c)
                ^ byt(shf, 4*c+1) ^ byt(shf, 4*c+2) ^ xtime(byt(shf, 4*c+3));
        end
        n_st = ((r_round == 4'd10) ? shf : mix) ^ n_rk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
            end else if (r_busy) begin
                r_round <= r_round + 4'd1;
                if (r_round == 4'd10) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_st   <= i_block ^ i_key;
            r_rk   <= i_key;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_st   <= n_st;
            r_rk   <= n_rk;
            r_rcon <= xtime(r_rcon);
        end
    end

    assign o_done  = r_done;
    assign o_block = r_st;

endmodule

// ----- rtl/kchs_deck.sv -----
module kchs_deck
    import kchs_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(MAX_CHANNELS)-1:0]  i_waddr,
    input  logic [HOP_W-1:0]                 i_wdata,
    input  logic [$clog2(MAX_CHANNELS)-1:0]  i_raddr,
    output logic [HOP_W-1:0]                 o_rdata
);

    logic [HOP_W-1:0] r_mem [MAX_CHANNELS];
    logic [HOP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/keyed_channel_hop_shuffle.sv -----
// channel  | signals                                   | direction
// request  | i_valid, o_stall, i_superframe            | in
// result   | o_valid, i_stall, o_hop_chan, o_deck_rebuilt | out
// config   | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
// A cache hit raises o_valid after a serial divide of the superframe by the count,
// a compare and a registered deck read.
// A rebuild adds two AES blocks, an identity load of one deck entry per cycle and
// the shuffle steps (a modulo, two reads and two writes each). Reset is synchronous
// and clears the cache.
// A stalled result holds in the output register; the next request waits at lookup.
module keyed_channel_hop_shuffle
    import kchs_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [SF_W-1:0]   i_superframe,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [HOP_W-1:0]  o_hop_chan,
    output logic              o_deck_rebuilt,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_CHANNELS);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DIV   = 11'b00000000010,
        S_CHK   = 11'b00000000100,
        S_AES0  = 11'b00000001000,
        S_AES1  = 11'b00000010000,
        S_INIT  = 11'b00000100000,
        S_RDI   = 11'b00001000000,
        S_RDJ   = 11'b00010000000,
        S_WR    = 11'b00100000000,
        S_LOOK  = 11'b01000000000,
        S_MOD   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [KEY_W-1:0] r_key_high;
    logic [KEY_W-1:0] r_key_low;
    logic [CNT_W-1:0] r_count_reg;
    logic [VAR_W-1:0] r_variant;
    logic [SF_W-1:0]  r_cached;
    logic             r_dvalid;
    logic [SF_W-1:0]  r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [5:0]       r_bit;
    logic [255:0]     r_stream;
    logic [AW-1:0]    r_i;
    logic [HOP_W-1:0] r_di;
    logic             r_wphase;
    logic             r_rebuilt;
    logic             r_ovalid;
    logic [HOP_W-1:0] r_ohop;
    logic             r_ocbit;
    logic             r_look2;
    logic [CNT_W-1:0] r_jrem;
    logic [7:0]       r_sb;
    logic [2:0]       r_mbit;

    logic [CNT_W-1:0] cnt;
    logic [CNT_W:0]   trial;
    logic [127:0]     key;
    logic [127:0]     blk;
    logic [127:0]     aes_in;
    logic [127:0]     aes_out;
    logic [127:0]     aes_fix;
    logic             aes_start;
    logic             aes_done;
    logic [4:0]       sidx;
    logic [7:0]       sbyte;
    logic [CNT_W-1:0] dvs;
    logic [CNT_W:0]   mtrial;
    logic [AW-1:0]    jidx;
    logic             out_load;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [HOP_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [HOP_W-1:0] mem_rdata;
    logic [31:0]      ctr;

    function automatic logic [127:0] rev_words(input logic [127:0] v);
        logic [127:0] o;
        for (int w = 0; w < 4; w++)
            for (int b = 0; b < 4; b++)
                o[127-8*(4*w+b) -: 8] = v[127-8*(4*w+3-b) -: 8];
        rev_words = o;
    endfunction

    always_comb begin
        if (r_count_reg < CNT_W'(2)) cnt = CNT_W'(2);
        else if (r_count_reg > CNT_W'(MAX_CHANNELS)) cnt = CNT_W'(MAX_CHANNELS);
        else cnt = r_count_reg;
        trial = {r_rem, r_quo[SF_W-1]} - {1'b0, cnt};
        key   = {r_key_high, r_key_low};
        ctr   = (r_variant == VAR_BIG) ? r_quo
              : {r_quo[7:0], r_quo[15:8], r_quo[23:16], r_quo[31:24]};
        blk   = {ctr, 88'd0, 7'd0, r_state == S_AES0};
        aes_in  = r_variant[1] ? rev_words(blk) : blk;
        aes_fix = r_variant[1] ? rev_words(aes_out) : aes_out;
        sidx  = 5'(r_i);
        sbyte = r_stream[255 - 8*sidx -: 8];
        dvs    = CNT_W'(r_i) + CNT_W'(1);
        mtrial = {r_jrem, r_sb[7]} - {1'b0, dvs};
        jidx   = r_jrem[AW-1:0];
    end

    assign aes_start = ((r_state == S_CHK) && (!r_dvalid || r_cached != r_quo))
                    || ((r_state == S_AES0) && aes_done);

    kchs_aes u_aes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (aes_start),
        .i_key   (key),
        .i_block (aes_in),
        .o_done  (aes_done),
        .o_block (aes_out)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = HOP_W'(r_i);
        mem_raddr = r_i;
        case (r_state)
            S_INIT: mem_we = 1'b1;
            S_RDI:  mem_raddr = r_i;
            S_RDJ:  mem_raddr = jidx;
            S_WR: begin
                mem_we = 1'b1;
                if (!r_wphase) begin
                    mem_waddr = r_i;
                    mem_wdata = mem_rdata;
                end else begin
                    mem_waddr = jidx;
                    mem_wdata = r_di;
                end
            end
            S_LOOK: mem_raddr = r_rem[AW-1:0];
            default: ;
        endcase
    end

    kchs_deck #(.MAX_CHANNELS(MAX_CHANNELS)) u_deck (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign out_load    = (r_state == S_LOOK) && r_look2 && (!r_ovalid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_count_reg <= CNT_W'(2);
            r_variant   <= '0;
            r_cached    <= '0;
            r_dvalid    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_dvalid <= 1'b0;
                        case (i_cfg_index)
                            REG_KEY_HIGH: r_key_high  <= i_cfg_data;
                            REG_KEY_LOW:  r_key_low   <= i_cfg_data;
                            REG_COUNT:    r_count_reg <= i_cfg_data[CNT_W-1:0];
                            REG_VARIANT:  r_variant   <= i_cfg_data[VAR_W-1:0];
                            default: ;
                        endcase
                    end else if (i_valid && !o_stall) begin
                        r_quo     <= i_superframe;
                        r_rem     <= '0;
                        r_bit     <= '0;
                        r_rebuilt <= 1'b0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[SF_W-2:0], !trial[CNT_W]};
                    r_rem <= trial[CNT_W] ? {r_rem[CNT_W-2:0], r_quo[SF_W-1]}
                                          : trial[CNT_W-1:0];
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'(SF_W - 1)) r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!r_dvalid || r_cached != r_quo) begin
                        r_cached  <= r_quo;
                        r_rebuilt <= 1'b1;
                        r_state   <= S_AES0;
                    end else begin
                        r_look2 <= 1'b0;
                        r_state <= S_LOOK;
                    end
                end
                S_AES0: if (aes_done) begin
                    r_stream[255:128] <= aes_fix;
                    r_state <= S_AES1;
                end
                S_AES1: if (aes_done) begin
                    r_stream[127:0] <= aes_fix;
                    r_i     <= '0;
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    if (CNT_W'(r_i) == cnt - CNT_W'(1)) r_state <= S_RDI;
                    else r_i <= r_i + AW'(1);
                end
                S_RDI: begin
                    r_jrem  <= '0;
                    r_sb    <= sbyte;
                    r_mbit  <= '0;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_sb   <= {r_sb[6:0], 1'b0};
                    r_jrem <= mtrial[CNT_W] ? {r_jrem[CNT_W-2:0], r_sb[7]}
                                            : mtrial[CNT_W-1:0];
                    r_mbit <= r_mbit + 3'd1;
                    if (r_mbit == 3'd7) r_state <= S_RDJ;
                end
                S_RDJ: begin
                    r_di     <= mem_rdata;
                    r_wphase <= 1'b0;
                    r_state  <= S_WR;
                end
                S_WR: begin
                    if (!r_wphase) begin
                        r_wphase <= 1'b1;
                    end else begin
                        if (r_i == AW'(1)) begin
                            r_dvalid <= 1'b1;
                            r_look2  <= 1'b0;
                            r_state  <= S_LOOK;
                        end else begin
                            r_i     <= r_i - AW'(1);
                            r_state <= S_RDI;
                        end
                    end
                end
                S_LOOK: begin
                    r_dvalid <= 1'b1;
                    r_look2  <= 1'b1;
                    if (out_load) begin
                        r_ohop  <= mem_rdata;
                        r_ocbit <= r_rebuilt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_hop_chan     = r_ohop;
    assign o_deck_rebuilt = r_ocbit;

endmodule

// ----- rtl/kchs_checker.sv -----
module kchs_checker
    import kchs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [HOP_W-1:0]  o_hop_chan,
    input logic              o_cfg_ready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hop_chan))
        else $error("result dropped under stall");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> o_stall)
        else $error("request open while busy");

    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_cfg_ready)
        else $error("config open during work");

endmodule

bind keyed_channel_hop_shuffle kchs_checker u_kchs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hop_chan  (o_hop_chan),
    .o_cfg_ready (o_cfg_ready)
);
